@@ rtl/tas_pkg.sv @@
// ----------------------------------------------------------------------------
// tas_pkg: shared definitions for the timed actuator sequencer
// Phase codes, command codes, register indexes, widths and the result record.
// ----------------------------------------------------------------------------
package tas_pkg;

  // Number of actuator channels in the timing table
  localparam int ACTUATORS   = 10;
  // Visible width of the actuator output field
  localparam int OUT_W       = 10;
  localparam int TIME_W      = 16;
  localparam int ELAPSED_W   = 17;
  localparam int COUNT_W     = 16;
  localparam int CMD_W       = 3;
  localparam int IDX_W       = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int ACT_CNT_W   = 4;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // Output drive levels
  localparam logic LOW  = 1'b0;
  localparam logic HIGH = 1'b1;

  typedef enum logic [2:0] {
    PH_HOME     = 3'd0,
    PH_WAIT     = 3'd1,
    PH_ACT      = 3'd2,
    PH_REMOVE   = 3'd3,
    PH_INACTIVE = 3'd4
  } phase_t;

  // Commands carried by an input transfer
  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_HOME  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DETECT_LEVEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_DETECT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_REMOVE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_INTV   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_LENGTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COUNT   = 3'd5;

  typedef struct packed {
    phase_t             phase;
    logic [OUT_W-1:0]   outputs;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

@@ rtl/timed_actuator_sequencer.sv @@
// ----------------------------------------------------------------------------
// timed_actuator_sequencer: five-phase actuator sequencer on 1 ms ticks
// Confirms object detection and removal over a timed interval and drives
// per-channel outputs from a start/stop timing table during actuation.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload
//  -------  -------------------  ---------------------------------------------
//  in_      in_valid / in_ready  cmd, sensor_level, actuator_index, start/stop
//  out_     out_valid/out_ready  phase, actuator_outputs, object_count
//  cfg_     cfg_we               cfg_index, cfg_data
//
//  One input transfer per cycle while in_ready is high; its result is registered.
//  The sequencer state updates in the accepting cycle from parallel compares.
//  Results sit in a two-entry output queue; in_ready drops only when full.
//  Reset (rst_n low, synchronous) gives phase home, timer, outputs, count zero.
//  The timing table has no reset and holds garbage until loaded.
//
module timed_actuator_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tas_pkg::CMD_W-1:0]     in_cmd,
  input  logic                          in_sensor_level,
  input  logic [tas_pkg::IDX_W-1:0]     in_actuator_index,
  input  logic [tas_pkg::TIME_W-1:0]    in_start_time,
  input  logic [tas_pkg::TIME_W-1:0]    in_stop_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_phase,
  output logic [tas_pkg::OUT_W-1:0]     out_actuator_outputs,
  output logic [tas_pkg::COUNT_W-1:0]   out_object_count,
  input  logic                          cfg_we,
  input  logic [tas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tas_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tas_pkg::*;

  // Configuration registers
  logic                 detect_level_r;
  logic                 confirm_detect_r;
  logic                 confirm_remove_r;
  logic [TIME_W-1:0]    confirm_intv_r;
  logic [TIME_W-1:0]    cycle_length_r;
  logic [ACT_CNT_W-1:0] active_count_r;

  // Sequencer state
  phase_t               phase_r, phase_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [ACTUATORS-1:0] out_bits_r, out_bits_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [TIME_W-1:0]    start_tbl_r [ACTUATORS];
  logic [TIME_W-1:0]    stop_tbl_r  [ACTUATORS];

  // Output queue
  result_t              q_r [2];
  logic [1:0]           q_cnt_r;

  logic                 in_xfer, out_xfer;
  logic                 present;
  logic [ELAPSED_W-1:0] el_inc;
  logic [ACTUATORS-1:0] used_mask;
  logic                 load_ok;
  result_t              res_new;

  assign in_ready = (q_cnt_r != 2'd2);
  assign in_xfer  = in_valid && in_ready;
  assign out_valid = (q_cnt_r != 2'd0);
  assign out_xfer  = out_valid && out_ready;

  assign present = (in_sensor_level == detect_level_r);
  assign el_inc  = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign load_ok = ({1'b0, in_actuator_index} < (IDX_W+1)'(ACTUATORS));

  // Mark the channels in use (active count limited to the table size)
  always_comb begin
    for (int i = 0; i < ACTUATORS; i++) begin
      used_mask[i] = ((ACT_CNT_W+1)'(i) < {1'b0, active_count_r});
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      detect_level_r   <= 1'b1;
      confirm_detect_r <= 1'b1;
      confirm_remove_r <= 1'b1;
      confirm_intv_r   <= TIME_W'(100);
      cycle_length_r   <= TIME_W'(1000);
      active_count_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DETECT_LEVEL:   detect_level_r   <= cfg_data[0];
        REG_CONFIRM_DETECT: confirm_detect_r <= cfg_data[0];
        REG_CONFIRM_REMOVE: confirm_remove_r <= cfg_data[0];
        REG_CONFIRM_INTV:   confirm_intv_r   <= cfg_data[TIME_W-1:0];
        REG_CYCLE_LENGTH:   cycle_length_r   <= cfg_data[TIME_W-1:0];
        REG_ACTIVE_COUNT:   active_count_r   <= cfg_data[ACT_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Next sequencer state for the item on the input ports
  always_comb begin
    phase_nxt    = phase_r;
    elapsed_nxt  = elapsed_r;
    out_bits_nxt = out_bits_r;
    count_nxt    = count_r;
    case (in_cmd)
      CMD_TICK: begin
        elapsed_nxt = el_inc;
        case (phase_r)
          PH_HOME: begin
            out_bits_nxt = out_bits_r & ~used_mask;
          end
          PH_WAIT: begin
            if (!confirm_detect_r) begin
              phase_nxt   = PH_ACT;
              elapsed_nxt = '0;
            end else if (present) begin
              if (el_inc > {1'b0, confirm_intv_r}) begin
                phase_nxt   = PH_ACT;
                elapsed_nxt = '0;
                count_nxt   = count_r + 1'b1;
              end
            end else begin
              elapsed_nxt = '0;
            end
          end
          PH_ACT: begin
            if (el_inc > {1'b0, cycle_length_r}) begin
              phase_nxt   = PH_REMOVE;
              elapsed_nxt = '0;
            end else begin
              // Stop wins over start on each channel
              for (int i = 0; i < ACTUATORS; i++) begin
                if (used_mask[i]) begin
                  if (el_inc > {1'b0, stop_tbl_r[i]}) begin
                    out_bits_nxt[i] = LOW;
                  end else if (el_inc > {1'b0, start_tbl_r[i]}) begin
                    out_bits_nxt[i] = HIGH;
                  end
                end
              end
            end
          end
          PH_REMOVE: begin
            if (!confirm_remove_r) begin
              phase_nxt   = PH_WAIT;
              elapsed_nxt = '0;
            end else if (!present) begin
              if (el_inc > {1'b0, confirm_intv_r}) begin
                phase_nxt   = PH_WAIT;
                elapsed_nxt = '0;
              end
            end else begin
              elapsed_nxt = '0;
            end
          end
          default: ;
        endcase
      end
      CMD_START: begin
        out_bits_nxt = out_bits_r & ~used_mask;
        phase_nxt    = PH_WAIT;
        elapsed_nxt  = '0;
      end
      CMD_STOP: begin
        phase_nxt   = PH_INACTIVE;
        elapsed_nxt = '0;
      end
      CMD_HOME: begin
        phase_nxt   = PH_HOME;
        elapsed_nxt = '0;
      end
      default: ;
    endcase
  end

  // Advance the state on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HOME;
      elapsed_r  <= '0;
      out_bits_r <= '0;
      count_r    <= '0;
    end else if (in_xfer) begin
      phase_r    <= phase_nxt;
      elapsed_r  <= elapsed_nxt;
      out_bits_r <= out_bits_nxt;
      count_r    <= count_nxt;
    end
  end

  // Load timing entries; out-of-range indexes drop
  always_ff @(posedge clk) begin
    for (int i = 0; i < ACTUATORS; i++) begin
      if (in_xfer && in_cmd == CMD_LOAD && load_ok && in_actuator_index == IDX_W'(i)) begin
        start_tbl_r[i] <= in_start_time;
        stop_tbl_r[i]  <= in_stop_time;
      end
    end
  end

  assign res_new.phase   = phase_nxt;
  assign res_new.outputs = OUT_W'(out_bits_nxt);
  assign res_new.count   = count_nxt;

  // Output queue: head in entry 0, shift on transfer out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
    end else begin
      q_cnt_r <= q_cnt_r + {1'b0, in_xfer} - {1'b0, out_xfer};
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer) begin
      if (q_cnt_r == 2'd2) begin
        q_r[0] <= q_r[1];
      end else if (in_xfer) begin
        q_r[0] <= res_new;
      end
    end else if (in_xfer) begin
      if (q_cnt_r == 2'd0) begin
        q_r[0] <= res_new;
      end else begin
        q_r[1] <= res_new;
      end
    end
  end

  assign out_phase            = q_r[0].phase;
  assign out_actuator_outputs = q_r[0].outputs;
  assign out_object_count     = q_r[0].count;

  // Queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r != 2'd3)
    else $error("output queue overflow");

  // Stop command lands in inactive with the timer cleared
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_cmd == CMD_STOP) |=> (phase_r == PH_INACTIVE && elapsed_r == '0))
    else $error("stop did not enter inactive");

  // Detection count moves by at most one per transfer
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (count_r == $past(count_r) || count_r == $past(count_r) + 1'b1))
    else $error("detection count jumped");

  // State holds without an input transfer
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_xfer |=> ($stable(phase_r) && $stable(elapsed_r) && $stable(out_bits_r)))
    else $error("state changed without a transfer");

  // Result of a transfer into an empty queue shows the new phase
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && q_cnt_r == 2'd0) |=> (out_valid && out_phase == phase_r))
    else $error("result does not match state");

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the timed actuator sequencer
// Drives command transfers with random gaps and result stalls, predicts every
// result from a behavioral copy of the sequencer state, and checks each
// result field. Directed tests cover the timing table, spare commands and
// extreme settings. Random tests walk full detect, actuate, remove sequences
// under several register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import tas_pkg::*;

  // Spare command codes that the sequencer must ignore
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [CMD_W-1:0]      in_cmd;
  logic                  in_sensor_level;
  logic [IDX_W-1:0]      in_actuator_index;
  logic [TIME_W-1:0]     in_start_time;
  logic [TIME_W-1:0]     in_stop_time;
  logic                  out_valid;
  logic                  out_ready;
  logic [2:0]            out_phase;
  logic [OUT_W-1:0]      out_actuator_outputs;
  logic [COUNT_W-1:0]    out_object_count;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  timed_actuator_sequencer DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_cmd               (in_cmd),
    .in_sensor_level      (in_sensor_level),
    .in_actuator_index    (in_actuator_index),
    .in_start_time        (in_start_time),
    .in_stop_time         (in_stop_time),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_phase            (out_phase),
    .out_actuator_outputs (out_actuator_outputs),
    .out_object_count     (out_object_count),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // Register copies
  logic                 want_level;
  logic                 confirm_detect_on;
  logic                 confirm_remove_on;
  logic [TIME_W-1:0]    hold_ms;
  logic [TIME_W-1:0]    cycle_ms;
  logic [ACT_CNT_W-1:0] used_count;

  // Sequencer state copies
  phase_t               seq_phase;
  logic [ELAPSED_W-1:0] timer_ms;
  logic [OUT_W-1:0]     drive_bits;
  logic [COUNT_W-1:0]   objects_seen;
  logic [TIME_W-1:0]    on_after  [ACTUATORS];
  logic [TIME_W-1:0]    off_after [ACTUATORS];

  result_t pending_results[$];
  int      mismatch_count;
  logic    idling_on;

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up on a hung run
  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void enter_phase(input phase_t next_phase);
    seq_phase = next_phase;
    timer_ms  = '0;
  endfunction

  // Advance the sequencer state by one command and return the result it shows
  function automatic result_t advance_sequencer(input logic [CMD_W-1:0] cmd,
                                                input logic lvl,
                                                input logic [IDX_W-1:0] idx,
                                                input logic [TIME_W-1:0] t_on,
                                                input logic [TIME_W-1:0] t_off);
    result_t r;
    logic    present;
    int      n;
    present = (lvl == want_level);
    n = (int'(used_count) > ACTUATORS) ? ACTUATORS : int'(used_count);
    case (cmd)
      CMD_TICK: begin
        if (timer_ms != ELAPSED_MAX) timer_ms = timer_ms + 1'b1;
        case (seq_phase)
          PH_HOME: begin
            for (int i = 0; i < n; i++) drive_bits[i] = LOW;
          end
          PH_WAIT: begin
            if (!confirm_detect_on) begin
              enter_phase(PH_ACT);
            end else if (present) begin
              if (timer_ms > hold_ms) begin
                enter_phase(PH_ACT);
                objects_seen = objects_seen + 1'b1;
              end
            end else begin
              enter_phase(PH_WAIT);
            end
          end
          PH_ACT: begin
            if (timer_ms > cycle_ms) begin
              enter_phase(PH_REMOVE);
            end else begin
              // stop time wins over start time
              for (int i = 0; i < n; i++) begin
                if (timer_ms > off_after[i]) drive_bits[i] = LOW;
                else if (timer_ms > on_after[i]) drive_bits[i] = HIGH;
              end
            end
          end
          PH_REMOVE: begin
            if (!confirm_remove_on) begin
              enter_phase(PH_WAIT);
            end else if (!present) begin
              if (timer_ms > hold_ms) enter_phase(PH_WAIT);
            end else begin
              enter_phase(PH_REMOVE);
            end
          end
          default: ;
        endcase
      end
      CMD_START: begin
        for (int i = 0; i < n; i++) drive_bits[i] = LOW;
        enter_phase(PH_WAIT);
      end
      CMD_STOP: enter_phase(PH_INACTIVE);
      CMD_HOME: enter_phase(PH_HOME);
      CMD_LOAD: begin
        if (int'(idx) < ACTUATORS) begin
          on_after[idx]  = t_on;
          off_after[idx] = t_off;
        end
      end
      default: ;
    endcase
    r.phase   = seq_phase;
    r.outputs = drive_bits;
    r.count   = objects_seen;
    return r;
  endfunction

  // Send one command transfer, with an occasional idle burst ahead of it
  task automatic push_command(input logic [CMD_W-1:0] cmd, input logic lvl,
                              input logic [IDX_W-1:0] idx,
                              input logic [TIME_W-1:0] t_on,
                              input logic [TIME_W-1:0] t_off);
    int gap;
    if (idling_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_cmd            <= cmd;
    in_sensor_level   <= lvl;
    in_actuator_index <= idx;
    in_start_time     <= t_on;
    in_stop_time      <= t_off;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(advance_sequencer(cmd, lvl, idx, t_on, t_off));
  endtask

  task automatic push_tick(input logic lvl);
    push_command(CMD_TICK, lvl, 4'($urandom_range(0, 15)), 16'($urandom),
                 16'($urandom));
  endtask

  // Hold off the sender until every outstanding result has been taken
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write one register while the sequencer is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DETECT_LEVEL:   want_level        = data[0];
      REG_CONFIRM_DETECT: confirm_detect_on = data[0];
      REG_CONFIRM_REMOVE: confirm_remove_on = data[0];
      REG_CONFIRM_INTV:   hold_ms           = data;
      REG_CYCLE_LENGTH:   cycle_ms          = data;
      REG_ACTIVE_COUNT:   used_count        = data[ACT_CNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic lvl, input logic cd, input logic cr,
                                input int intv, input int cyc, input int act);
    write_reg(REG_DETECT_LEVEL, 16'(lvl));
    write_reg(REG_CONFIRM_DETECT, 16'(cd));
    write_reg(REG_CONFIRM_REMOVE, 16'(cr));
    write_reg(REG_CONFIRM_INTV, 16'(intv));
    write_reg(REG_CYCLE_LENGTH, 16'(cyc));
    write_reg(REG_ACTIVE_COUNT, 16'(act));
  endtask

  // Fill every timing entry, then try loads past the end of the table
  task automatic test_table_load();
    push_command(CMD_LOAD, 1'b0, 4'd0, 16'h0000, 16'hFFFF);
    push_command(CMD_LOAD, 1'b1, 4'd1, 16'hFFFF, 16'h0000);
    for (int i = 2; i < ACTUATORS; i++)
      push_command(CMD_LOAD, 1'($urandom), 4'(i), 16'(i), 16'(i + 3));
    push_command(CMD_LOAD, 1'b0, 4'd10, 16'($urandom), 16'($urandom));
    push_command(CMD_LOAD, 1'b1, 4'd15, 16'($urandom), 16'($urandom));
  endtask

  // Spare command codes leave everything as it is
  task automatic test_spare_commands();
    for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
      push_command(3'(c), 1'($urandom), 4'($urandom_range(0, 15)), 16'($urandom),
                   16'($urandom));
  endtask

  // Longest interval and cycle: nothing times out within a few ticks
  task automatic test_extreme_settings();
    apply_settings(1'b1, 1'b0, 1'b1, 65535, 65535, 10);
    push_command(CMD_START, 1'b0, 4'd0, 16'd0, 16'd0);
    push_tick(1'b1);
    repeat (3) push_tick(1'($urandom));
    push_command(CMD_STOP, 1'b1, 4'd0, 16'd0, 16'd0);
    push_tick(1'b1);
    push_command(CMD_HOME, 1'b0, 4'd0, 16'd0, 16'd0);
    push_tick(1'b0);
    write_reg(REG_CONFIRM_DETECT, 16'd1);
    push_command(CMD_START, 1'b1, 4'd0, 16'd0, 16'd0);
    repeat (2) push_tick(1'b1);
  endtask

  // Zero interval and cycle: each confirmation passes on its first tick
  task automatic test_zero_settings();
    apply_settings(1'b1, 1'b1, 1'b1, 0, 0, 0);
    push_command(CMD_START, 1'b0, 4'd0, 16'd0, 16'd0);
    push_tick(1'b1);
    push_tick(1'b0);
    push_tick(1'b1);
    push_tick(1'b0);
    push_tick(1'b0);
  endtask

  // Mostly well-formed sequences steered by the predicted phase, plus noise
  task automatic run_random_sequences(input int n_items, input int time_span);
    int pick;
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        push_command(CMD_STOP, 1'($urandom), 4'($urandom_range(0, 15)), 16'($urandom),
                     16'($urandom));
      end else if (pick < 6) begin
        push_command(CMD_HOME, 1'($urandom), 4'($urandom_range(0, 15)), 16'($urandom),
                     16'($urandom));
      end else if (pick < 10) begin
        if ($urandom_range(0, 3) != 0)
          push_command(CMD_LOAD, 1'($urandom), 4'($urandom_range(0, 15)),
                       16'($urandom_range(0, time_span)),
                       16'($urandom_range(0, time_span)));
        else
          push_command(CMD_LOAD, 1'($urandom), 4'($urandom_range(0, 15)), 16'($urandom),
                       16'($urandom));
      end else if (pick < 12) begin
        push_command(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), 1'($urandom),
                     4'($urandom_range(0, 15)), 16'($urandom), 16'($urandom));
      end else if (pick < 14 || ((seq_phase == PH_HOME || seq_phase == PH_INACTIVE)
                                 && $urandom_range(0, 2) == 0)) begin
        push_command(CMD_START, 1'($urandom), 4'($urandom_range(0, 15)), 16'($urandom),
                     16'($urandom));
      end else if (seq_phase == PH_WAIT) begin
        push_tick($urandom_range(0, 99) < 85 ? want_level : ~want_level);
      end else if (seq_phase == PH_REMOVE) begin
        push_tick($urandom_range(0, 99) < 85 ? ~want_level : want_level);
      end else begin
        push_tick(1'($urandom));
      end
    end
  endtask

  // Random sequences under several register settings, the last without idling
  task automatic test_random_sequences();
    apply_settings(1'b1, 1'b1, 1'b1, 2, 15, 10);
    run_random_sequences(175, 18);
    apply_settings(1'b0, 1'b1, 1'b1, 0, 0, 15);
    run_random_sequences(175, 4);
    apply_settings(1'b1, 1'b0, 1'b0, 5, 25, 5);
    run_random_sequences(175, 30);
    apply_settings(1'($urandom), 1'($urandom), 1'($urandom), $urandom_range(0, 6),
                   $urandom_range(0, 40), $urandom_range(0, 15));
    run_random_sequences(175, 45);
    wait_for_results();
    idling_on = 1'b0;
    apply_settings(1'b1, 1'b1, 1'b1, 3, 30, 10);
    run_random_sequences(175, 35);
  endtask

  // Result-side stalls in random bursts
  initial begin
    int stall;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(0, 11);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    result_t head;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result: none expected, got phase %0d outputs %h count %0d",
               out_phase, out_actuator_outputs, out_object_count);
        mismatch_count++;
      end else begin
        head = pending_results.pop_front();
        if (out_phase !== head.phase) begin
          $error("phase: expected %0d, actual %0d", head.phase, out_phase);
          mismatch_count++;
        end
        if (out_actuator_outputs !== head.outputs) begin
          $error("actuator_outputs: expected %h, actual %h", head.outputs,
                 out_actuator_outputs);
          mismatch_count++;
        end
        if (out_object_count !== head.count) begin
          $error("object_count: expected %0d, actual %0d", head.count, out_object_count);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    idling_on         = 1'b1;
    mismatch_count    = 0;
    want_level        = 1'b1;
    confirm_detect_on = 1'b1;
    confirm_remove_on = 1'b1;
    hold_ms           = 16'd100;
    cycle_ms          = 16'd1000;
    used_count        = '0;
    seq_phase         = PH_HOME;
    timer_ms          = '0;
    drive_bits        = '0;
    objects_seen      = '0;
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_cmd            <= CMD_TICK;
    in_sensor_level   <= 1'b0;
    in_actuator_index <= '0;
    in_start_time     <= '0;
    in_stop_time      <= '0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_DETECT_LEVEL;
    cfg_data          <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_table_load();
    test_spare_commands();
    test_extreme_settings();
    test_zero_settings();
    test_random_sequences();

    // Drain, then let the pipeline settle before judging
    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
